### rtl/core/bb3_pkg.sv
// Package for the 3x3 RGB box blur core: pixel, job and sum types, divisor
// codes and reciprocal constants for the averaging pipeline.
// No dependencies.
package bb3_pkg;

  localparam int CHAN_W    = 16;
  localparam int CFG_W     = 11;
  localparam int CFG_RESET = 32;
  localparam int POS_OUT_W = 10;
  localparam int CSUM_W    = CHAN_W + 2;
  localparam int HSUM_W    = CHAN_W + 4;

  localparam int RECIP_SHIFT = HSUM_W + 4;
  localparam int RECIP_W     = RECIP_SHIFT - 1;
  localparam int PROD_W      = HSUM_W + RECIP_W;

  localparam int RECIP_4 = (1 << RECIP_SHIFT) / 4;
  localparam int RECIP_6 = ((1 << RECIP_SHIFT) + 5) / 6;
  localparam int RECIP_9 = ((1 << RECIP_SHIFT) + 8) / 9;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [1:0] DIV4 = 2'd0;
  localparam logic [1:0] DIV6 = 2'd1;
  localparam logic [1:0] DIV9 = 2'd2;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][CHAN_W-1:0] pix_t;
  // row 0 is r-2, row 1 is r-1, row 2 is r
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  typedef logic [2:0][CSUM_W-1:0] csum_t;
  typedef csum_t [2:0] cset_t;

  typedef struct packed {
    cset_t                sum_a;
    cset_t                sum_b;
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 top3;
    logic                 left3;
    logic                 bot;
    logic                 right;
  } job_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 run_end;
    logic                 frame_end;
  } meta_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [1:0] code);
    logic [RECIP_W-1:0] r;
    case (code)
      DIV6:    r = RECIP_W'(RECIP_6);
      DIV9:    r = RECIP_W'(RECIP_9);
      default: r = RECIP_W'(RECIP_4);
    endcase
    return r;
  endfunction

endpackage

### rtl/core/box_blur_3x3_rgb_core.sv
// Top level of the streaming 3x3 RGB box blur: front end, job queue and back end.
// Depends on bb3_pkg, bb3_front, bb3_fifo and bb3_back.
//
// Channel  Handshake              Payload                                   Transfer
// in       in_valid / in_ready    in_red, in_green, in_blue                 one raster pixel
// out      out_valid / out_ready  out_row, out_col, out_red/green/blue,     one smoothed pixel
//                                 out_run_end, out_frame_end
// cfg      cfg_we                 cfg_wdata (image side)                    one write, no wait
//
// One pixel per cycle in while the job queue has room; the averaging pipeline
// gives one result per cycle while out_ready is high. The last image row and column
// yield two results per pixel and the corner four, so there the four-entry job
// queue fills and input is held off while the back end works through its jobs.
// Reset is synchronous, active low; the line memory is not cleared.
// A cfg write restarts the frame at pixel (0,0).
module box_blur_3x3_rgb_core #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bb3_pkg::CHAN_W-1:0]    in_red,
  input  logic [bb3_pkg::CHAN_W-1:0]    in_green,
  input  logic [bb3_pkg::CHAN_W-1:0]    in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bb3_pkg::POS_OUT_W-1:0] out_row,
  output logic [bb3_pkg::POS_OUT_W-1:0] out_col,
  output logic [bb3_pkg::CHAN_W-1:0]    out_red,
  output logic [bb3_pkg::CHAN_W-1:0]    out_green,
  output logic [bb3_pkg::CHAN_W-1:0]    out_blue,
  output logic                          out_run_end,
  output logic                          out_frame_end
);
  import bb3_pkg::*;

  pix_t in_pix;
  job_t push_job;
  job_t head_job;
  logic job_push;
  logic q_space;
  logic q_not_empty;
  logic q_pop;

  assign in_pix[0] = in_red;
  assign in_pix[1] = in_green;
  assign in_pix[2] = in_blue;

  bb3_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (in_pix),
    .job_push  (job_push),
    .job       (push_job),
    .q_space   (q_space)
  );

  bb3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .has_space (q_space),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  bb3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_not_empty),
    .head          (head_job),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_run_end   (out_run_end),
    .out_frame_end (out_frame_end)
  );

endmodule

### rtl/core/bb3_front.sv
// Front end of the box blur: pixel intake, position counters, line memory,
// window columns and vertical partial sums. Pushes one job per pixel with results.
// Depends on bb3_pkg.
module bb3_front #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [bb3_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bb3_pkg::pix_t            in_pix,
  output logic                     job_push,
  output bb3_pkg::job_t            job,
  input  logic                     q_space
);
  import bb3_pkg::*;

  localparam int POS_W    = $clog2(MAX_SIDE);
  localparam int RST_SIDE = (MAX_SIDE < CFG_RESET) ? MAX_SIDE : CFG_RESET;

  logic [POS_W-1:0] last_r, last_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [31:0]      size_w;
  logic [POS_W-1:0] cfg_last;
  logic             in_acc;

  logic             f1_valid_r;
  pix_t             f1_px_r;
  logic [POS_W-1:0] f1_col_r;
  logic [POS_W-1:0] f1_row_r;
  logic             f1_emit_r;
  logic             f1_top3_r;
  logic             f1_left3_r;
  logic             f1_bot_r;
  logic             f1_right_r;
  logic             f1_adv;

  line_t            line_mem [MAX_SIDE];
  line_t            rd_q;
  col_t             win0_r;
  col_t             win1_r;
  col_t             col2;
  col_t [2:0]       wcol;

  assign size_w   = 32'(cfg_wdata);
  assign cfg_last = (size_w < 32'd2) ? POS_W'(1) :
                    (size_w > 32'(MAX_SIDE)) ? POS_W'(MAX_SIDE - 1) :
                    POS_W'(size_w - 32'd1);

  assign f1_adv   = f1_valid_r && (!f1_emit_r || q_space);
  assign in_ready = !f1_valid_r || f1_adv;
  assign in_acc   = in_valid && in_ready;
  assign job_push = f1_valid_r && f1_emit_r && q_space;

  always_comb begin
    last_nxt = last_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cfg_we) begin
      last_nxt = cfg_last;
      row_nxt  = '0;
      col_nxt  = '0;
    end else if (in_acc) begin
      if (col_r == last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_r) ? '0 : row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r     <= POS_W'(RST_SIDE - 1);
      row_r      <= '0;
      col_r      <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      last_r     <= last_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      f1_valid_r <= in_acc ? 1'b1 : (f1_adv ? 1'b0 : f1_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f1_px_r    <= in_pix;
      f1_row_r   <= row_r;
      f1_col_r   <= col_r;
      f1_emit_r  <= (row_r != '0) && (col_r != '0);
      f1_top3_r  <= row_r > POS_W'(1);
      f1_left3_r <= col_r > POS_W'(1);
      f1_bot_r   <= row_r == last_r;
      f1_right_r <= col_r == last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q <= line_mem[col_r];
    end
    if (f1_adv) begin
      line_mem[f1_col_r] <= '{older: rd_q.newer, newer: f1_px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (f1_adv) begin
      win0_r <= win1_r;
      win1_r <= col2;
    end
  end

  always_comb begin
    col2[0] = rd_q.older;
    col2[1] = rd_q.newer;
    col2[2] = f1_px_r;
    wcol[0] = win0_r;
    wcol[1] = win1_r;
    wcol[2] = col2;
  end

  always_comb begin
    job       = '0;
    job.row   = POS_OUT_W'(f1_row_r);
    job.col   = POS_OUT_W'(f1_col_r);
    job.top3  = f1_top3_r;
    job.left3 = f1_left3_r;
    job.bot   = f1_bot_r;
    job.right = f1_right_r;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        job.sum_b[j][k] = CSUM_W'(wcol[j][1][k]) + CSUM_W'(wcol[j][2][k]);
        job.sum_a[j][k] = job.sum_b[j][k] +
                          (f1_top3_r ? CSUM_W'(wcol[j][0][k]) : CSUM_W'(0));
      end
    end
  end

endmodule

### rtl/core/bb3_fifo.sv
// Job queue between the front end and the averaging back end.
// Small register file with head read; depends on bb3_pkg.
module bb3_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bb3_pkg::job_t push_data,
  output logic          has_space,
  input  logic          pop,
  output logic          not_empty,
  output bb3_pkg::job_t head
);
  import bb3_pkg::*;

  job_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign has_space = count_r != (Q_AW + 1)'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (Q_AW + 1)'(1);
        2'b01:   count_r <= count_r - (Q_AW + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/bb3_back.sv
// Back end of the box blur: expands a job into its smoothed pixels, sums the
// columns and divides by 4, 6 or 9 through a reciprocal multiply. Depends on bb3_pkg.
module bb3_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  bb3_pkg::job_t                head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bb3_pkg::POS_OUT_W-1:0] out_row,
  output logic [bb3_pkg::POS_OUT_W-1:0] out_col,
  output logic [bb3_pkg::CHAN_W-1:0]   out_red,
  output logic [bb3_pkg::CHAN_W-1:0]   out_green,
  output logic [bb3_pkg::CHAN_W-1:0]   out_blue,
  output logic                         out_run_end,
  output logic                         out_frame_end
);
  import bb3_pkg::*;

  logic                   adv;
  logic                   yi_r;
  logic                   xi_r;
  logic                   last_sub;
  logic                   issue;
  cset_t                  sel;
  logic [2:0][HSUM_W-1:0] hsum;
  logic                   rows3;
  logic                   cols3;
  logic [1:0]             div_code;
  meta_t                  meta;

  logic                   b1_valid_r;
  logic [2:0][HSUM_W-1:0] b1_sum_r;
  logic [RECIP_W-1:0]     b1_rcp_r;
  meta_t                  b1_meta_r;

  logic                   b2_valid_r;
  logic [2:0][PROD_W-1:0] b2_prod_r;
  meta_t                  b2_meta_r;

  logic                   out_valid_r;
  pix_t                   out_pix_r;
  meta_t                  out_meta_r;

  assign adv      = !out_valid_r || out_ready;
  assign issue    = adv && head_valid;
  assign last_sub = (xi_r || !head.right) && (yi_r || !head.bot);
  assign pop      = issue && last_sub;

  always_comb begin
    logic [HSUM_W-1:0] side_sum;
    sel = yi_r ? head.sum_b : head.sum_a;
    for (int k = 0; k < 3; k++) begin
      side_sum = HSUM_W'(sel[1][k]) + HSUM_W'(sel[2][k]);
      hsum[k]  = (!xi_r && head.left3) ? side_sum + HSUM_W'(sel[0][k]) : side_sum;
    end
    rows3 = !yi_r && head.top3;
    cols3 = !xi_r && head.left3;
    if (rows3 && cols3) begin
      div_code = DIV9;
    end else if (rows3 || cols3) begin
      div_code = DIV6;
    end else begin
      div_code = DIV4;
    end
    meta.row       = yi_r ? head.row : head.row - POS_OUT_W'(1);
    meta.col       = xi_r ? head.col : head.col - POS_OUT_W'(1);
    meta.run_end   = last_sub;
    meta.frame_end = yi_r && xi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yi_r        <= 1'b0;
      xi_r        <= 1'b0;
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        if (last_sub) begin
          yi_r <= 1'b0;
          xi_r <= 1'b0;
        end else if (!xi_r && head.right) begin
          xi_r <= 1'b1;
        end else begin
          yi_r <= 1'b1;
          xi_r <= 1'b0;
        end
      end
      if (adv) begin
        b1_valid_r  <= head_valid;
        b2_valid_r  <= b1_valid_r;
        out_valid_r <= b2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sum_r  <= hsum;
      b1_rcp_r  <= recip(div_code);
      b1_meta_r <= meta;
      for (int k = 0; k < 3; k++) begin
        b2_prod_r[k] <= {{RECIP_W{1'b0}}, b1_sum_r[k]} * {{HSUM_W{1'b0}}, b1_rcp_r};
        out_pix_r[k] <= b2_prod_r[k][RECIP_SHIFT +: CHAN_W];
      end
      b2_meta_r  <= b1_meta_r;
      out_meta_r <= b2_meta_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_meta_r.row;
  assign out_col       = out_meta_r.col;
  assign out_red       = out_pix_r[0];
  assign out_green     = out_pix_r[1];
  assign out_blue      = out_pix_r[2];
  assign out_run_end   = out_meta_r.run_end;
  assign out_frame_end = out_meta_r.frame_end;

endmodule

### rtl/core/bb3_checker.sv
// Port-level checks for box_blur_3x3_rgb_core, attached by bind.
// Depends on bb3_pkg for field widths.
module bb3_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bb3_pkg::POS_OUT_W-1:0] out_row,
  input logic [bb3_pkg::POS_OUT_W-1:0] out_col,
  input logic [bb3_pkg::CHAN_W-1:0]    out_red,
  input logic [bb3_pkg::CHAN_W-1:0]    out_green,
  input logic [bb3_pkg::CHAN_W-1:0]    out_blue,
  input logic                          out_run_end,
  input logic                          out_frame_end
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue) &&
      $stable(out_run_end) && $stable(out_frame_end))
    else $error("result changed while stalled");

  a_frame_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_end)
    else $error("frame end not on last result of its pixel");

  a_frame_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row == out_col)
    else $error("frame end away from the bottom-right corner");

  // results of one pixel leave back to back
  a_run_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_end |=> out_valid)
    else $error("gap inside the results of one pixel");

endmodule

bind box_blur_3x3_rgb_core bb3_checker u_bb3_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row       (out_row),
  .out_col       (out_col),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue),
  .out_run_end   (out_run_end),
  .out_frame_end (out_frame_end)
);

### verif/tb.sv
// Testbench for box_blur_3x3_rgb_core: streams raster pixels under random idling and
// checks every smoothed pixel against an in-bench 3x3 edge-clipped mean predictor.
// Depends on bb3_pkg and the box_blur_3x3_rgb_core RTL.
`timescale 1ns / 100ps

module tb;
  import bb3_pkg::*;

  localparam int MAX_SIDE      = 1024;
  localparam int POS_W         = $clog2(MAX_SIDE);
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 300;

  typedef struct {
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic                 run_end;
    logic                 frame_end;
  } blur_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [POS_OUT_W-1:0] out_row;
  logic [POS_OUT_W-1:0] out_col;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic                 out_run_end;
  logic                 out_frame_end;

  // stimulus and scoreboard
  pix_t        pixel_q [$];
  blur_res_t   blurred_q [$];
  logic        in_taken = 1'b0;
  logic        calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  pix_t        drv_px;

  // predictor state
  logic [CFG_W-1:0] img_side = CFG_W'(CFG_RESET);
  int unsigned      next_row = 0;
  int unsigned      next_col = 0;
  pix_t             older_line [MAX_SIDE];
  pix_t             newer_line [MAX_SIDE];
  pix_t             win_hist [6];

  box_blur_3x3_rgb_core #(
    .MAX_SIDE(MAX_SIDE)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_run_end  (out_run_end),
    .out_frame_end(out_frame_end)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CHAN_W'($urandom);
  endfunction

  function automatic pix_t rand_pix();
    pix_t px;
    px[0] = rand_chan();
    px[1] = rand_chan();
    px[2] = rand_chan();
    return px;
  endfunction

  // expected smoothed pixels caused by one accepted input pixel
  task automatic blur_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                            input logic [CHAN_W-1:0] blue);
    int unsigned side, r, c, y, x, y0, y1, x0, x1, yy, xx, cnt, ny, nx, a, b, k;
    int unsigned ys [2];
    int unsigned xs [2];
    int unsigned sum [3];
    logic [1:0]  wy;
    logic [1:0]  wx;
    pix_t        px;
    pix_t        p;
    pix_t        win [3][3];
    blur_res_t   res;
    side = 32'(img_side);
    if (side < 2) side = 2;
    else if (side > MAX_SIDE) side = MAX_SIDE;
    r = next_row;
    c = next_col;
    if (r >= side || c >= side) begin
      r = 0;
      c = 0;
    end
    px[0] = red;
    px[1] = green;
    px[2] = blue;
    win[0][0] = win_hist[0];
    win[0][1] = win_hist[1];
    win[0][2] = older_line[c[POS_W-1:0]];
    win[1][0] = win_hist[2];
    win[1][1] = win_hist[3];
    win[1][2] = newer_line[c[POS_W-1:0]];
    win[2][0] = win_hist[4];
    win[2][1] = win_hist[5];
    win[2][2] = px;
    ny = 0;
    nx = 0;
    if (r >= 1) begin
      ys[ny[0]] = r - 1;
      ny++;
    end
    if (r == side - 1) begin
      ys[ny[0]] = r;
      ny++;
    end
    if (c >= 1) begin
      xs[nx[0]] = c - 1;
      nx++;
    end
    if (c == side - 1) begin
      xs[nx[0]] = c;
      nx++;
    end
    for (a = 0; a < ny; a++) begin
      for (b = 0; b < nx; b++) begin
        y = ys[a[0]];
        x = xs[b[0]];
        y0 = (y == 0) ? 0 : y - 1;
        y1 = (y + 1 > side - 1) ? side - 1 : y + 1;
        x0 = (x == 0) ? 0 : x - 1;
        x1 = (x + 1 > side - 1) ? side - 1 : x + 1;
        sum[0] = 0;
        sum[1] = 0;
        sum[2] = 0;
        cnt = 0;
        for (yy = y0; yy <= y1; yy++) begin
          for (xx = x0; xx <= x1; xx++) begin
            wy = 2'((yy + 2 - r) % 3);
            wx = 2'((xx + 2 - c) % 3);
            p = win[wy][wx];
            for (k = 0; k < 3; k++) sum[k[1:0]] += 32'(p[k[1:0]]);
            cnt++;
          end
        end
        res.row       = POS_OUT_W'(y);
        res.col       = POS_OUT_W'(x);
        res.red       = CHAN_W'(sum[0] / cnt);
        res.green     = CHAN_W'(sum[1] / cnt);
        res.blue      = CHAN_W'(sum[2] / cnt);
        res.run_end   = (a == ny - 1) && (b == nx - 1);
        res.frame_end = (y == side - 1) && (x == side - 1);
        blurred_q.push_back(res);
      end
    end
    win_hist[0] = win[0][1];
    win_hist[1] = win[0][2];
    win_hist[2] = win[1][1];
    win_hist[3] = win[1][2];
    win_hist[4] = win[2][1];
    win_hist[5] = win[2][2];
    older_line[c[POS_W-1:0]] = newer_line[c[POS_W-1:0]];
    newer_line[c[POS_W-1:0]] = px;
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    blur_res_t want;
    if (blurred_q.size() == 0) begin
      $error("out: transfer with nothing expected, row %0d col %0d", out_row, out_col);
      mismatches++;
    end else begin
      want = blurred_q.pop_front();
      check_field("out_row", CHAN_W'(want.row), CHAN_W'(out_row));
      check_field("out_col", CHAN_W'(want.col), CHAN_W'(out_col));
      check_field("out_red", want.red, out_red);
      check_field("out_green", want.green, out_green);
      check_field("out_blue", want.blue, out_blue);
      check_field("out_run_end", CHAN_W'(want.run_end), CHAN_W'(out_run_end));
      check_field("out_frame_end", CHAN_W'(want.frame_end), CHAN_W'(out_frame_end));
    end
  endtask

  // drive pixels: hold until transfer, then idle for a random gap
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0 || pixel_q.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        drv_px = pixel_q.pop_front();
        in_red   <= drv_px[0];
        in_green <= drv_px[1];
        in_blue  <= drv_px[2];
        in_valid <= 1'b1;
        in_gap   <= pick_gap();
      end
    end
  end

  // stall the result side at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
    if ($urandom_range(0, 299) == 0) calm <= !calm;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_valid && in_ready;
      if (cfg_we) begin
        img_side = cfg_wdata;
        next_row = 0;
        next_col = 0;
      end
      if (in_taken) blur_pixel(in_red, in_green, in_blue);
      if (out_valid && out_ready) check_result();
      if (in_taken || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // hold until every pixel is sent and every result is in, then settle
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || in_valid || blurred_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_side(input logic [CFG_W-1:0] side);
    drain();
    @(negedge clk);
    cfg_wdata <= side;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned      i, n, d, sent, roll;
    logic [CFG_W-1:0] side;
    pix_t             px;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 2 * CFG_RESET + 3; i++) pixel_q.push_back(rand_pix());

    set_side(CFG_W'(2));
    px = '1;
    for (i = 0; i < 4; i++) pixel_q.push_back(px);
    px = '0;
    for (i = 0; i < 4; i++) pixel_q.push_back(px);

    set_side(CFG_W'(0));
    pixel_q.push_back({16'h0000, 16'hFFFF, 16'h0000});
    pixel_q.push_back({16'hFFFF, 16'h0000, 16'hFFFF});
    pixel_q.push_back({16'hFFFF, 16'hFFFF, 16'h0000});
    pixel_q.push_back({16'h0000, 16'h0000, 16'hFFFF});

    set_side(CFG_W'(1));
    pixel_q.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
    pixel_q.push_back({16'h5555, 16'hAAAA, 16'h5555});
    pixel_q.push_back({16'h8000, 16'h7FFF, 16'h0001});
    pixel_q.push_back({16'h0001, 16'hFFFE, 16'h8000});

    set_side(CFG_W'(3));
    for (i = 0; i < 9; i++) begin
      px[0] = 16'hFFFF - CHAN_W'(i);
      px[1] = CHAN_W'(i);
      px[2] = (i % 2 == 1) ? 16'hFFFF : 16'h0000;
      pixel_q.push_back(px);
    end

    set_side('1);
    for (i = 0; i < 12; i++) pixel_q.push_back(rand_pix());

    sent = 0;
    d = 2;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) side = CFG_W'($urandom_range(0, 1));
        else if (roll < 85) side = CFG_W'($urandom_range(2, 9));
        else side = CFG_W'($urandom_range(10, 40));
        d = 32'(side);
        if (d < 2) d = 2;
        set_side(side);
      end else begin
        drain();
      end
      n = d * d * $urandom_range(0, 2) + $urandom_range(1, d * d);
      if (n > 200) n = 200;
      for (i = 0; i < n; i++) pixel_q.push_back(rand_pix());
      sent += n;
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### box_blur_3x3_rgb_core.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_front.sv
rtl/core/bb3_fifo.sv
rtl/core/bb3_back.sv
rtl/core/box_blur_3x3_rgb_core.sv
rtl/core/bb3_checker.sv
verif/tb.sv
